[rtl/actor_critic_table_learner_macros.svh]
// assertion macros of the learner rtl, used by actc_ctrl
`ifndef ACTOR_CRITIC_TABLE_LEARNER_MACROS_SVH
`define ACTOR_CRITIC_TABLE_LEARNER_MACROS_SVH

// same-cycle implication
`define ACTC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("actc assertion failed");

// next-cycle implication
`define ACTC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("actc assertion failed");

`endif

[rtl/actc_pkg.sv]
// types, constants and helpers of the actor-critic table learner
package actc_pkg;

  localparam int NS = 1024;
  localparam int NA = 4;
  localparam int VW = 32;
  localparam int SW = $clog2(NS);
  localparam int AW = $clog2(NA);

  localparam int OP_W = 2;
  localparam int ACT_W = 2;
  localparam int REW_W = 32;
  localparam int VD_W = 32;
  localparam int CH_W = 2;
  localparam int ST_FIELD_W = 10;

  localparam int PS_LSB = 0;
  localparam int CS_LSB = PS_LSB + ST_FIELD_W;
  localparam int ACT_LSB = CS_LSB + ST_FIELD_W;
  localparam int REW_LSB = ACT_LSB + ACT_W;
  localparam int IN_W = 56;
  localparam int OUT_W = 40;

  localparam int LR_W = 15;
  localparam int AS_W = 31;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 31;
  localparam logic [LR_W-1:0] LEARN_RATE_RST = 15'd31130;
  localparam logic [LR_W-1:0] DISCOUNT_RST = 15'd29491;
  localparam logic [AS_W-1:0] ACTOR_STEP_RST = 31'd19661;

  localparam int FRAC_W = 16;
  localparam int SUM_W = VW + AW + 1;
  localparam int DVD_W = VW + FRAC_W;
  localparam int GP_W = VW + LR_W + 1;
  localparam int TD_W = ((VW > REW_W) ? VW : REW_W) + 3;
  localparam int AP_W = TD_W + LR_W + 1;
  localparam int ROUND = 1 << (LR_W - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEARN_RATE = 2'd0,
    REG_DISCOUNT   = 2'd1,
    REG_ACTOR_STEP = 2'd2
  } reg_idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_CRITIC = 2'd0,
    OP_ACTOR  = 2'd1,
    OP_CHOOSE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_CUR,
    ST_RD_PREV,
    ST_CAPTURE,
    ST_MUL_G,
    ST_TD,
    ST_MUL_A,
    ST_WR_CRITIC,
    ST_ADD,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_WR_ACTOR,
    ST_OUT
  } state_t;

  typedef logic [NA-1:0][VW-1:0] row_t;

  typedef struct packed {
    logic          accept;
    logic          clr;
    logic [SW-1:0] clr_addr;
    logic          rd_prev;
    logic          cap_cur;
    logic          cap_prev;
    logic          mul_g;
    logic          td_calc;
    logic          mul_a;
    logic          wr_critic;
    logic          add_row;
    logic          div_start;
    logic [AW-1:0] ent;
    logic          wr_actor;
    logic          load_out;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic sum_zero;
    logic div_done;
  } status_t;

  // lowest index wins on ties
  function automatic logic [AW-1:0] row_argmax(input row_t r);
    logic [AW-1:0] best;
    best = '0;
    for (int a = 1; a < NA; a++) begin
      if ($signed(r[a]) > $signed(r[best])) best = AW'(a);
    end
    return best;
  endfunction

endpackage

[rtl/actc_div.sv]
// restoring divider, one quotient bit per cycle
module actc_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [actc_pkg::DVD_W-1:0] dividend,
  input  logic [actc_pkg::SUM_W-1:0] divisor,
  output logic                      done,
  output logic [actc_pkg::DVD_W-1:0] quot
);
  import actc_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic [SUM_W-1:0] rem;
  logic [DVD_W-1:0] qr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [SUM_W+1:0] diff;

  assign diff = {1'b0, rem, qr[DVD_W-1]} - {2'b00, divisor};
  assign quot = qr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(DVD_W - 1);
      end else if (busy) begin
        if (cnt == '0) busy <= 1'b0;
        else cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      qr <= dividend;
    end else if (busy) begin
      if (!diff[SUM_W+1]) begin
        rem <= diff[SUM_W-1:0];
        qr <= {qr[DVD_W-2:0], 1'b1};
      end else begin
        rem <= {rem[SUM_W-2:0], qr[DVD_W-1]};
        qr <= {qr[DVD_W-2:0], 1'b0};
      end
    end
  end

endmodule

[rtl/actc_datapath.sv]
// tables, arithmetic and result register of the learner
module actc_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  actc_pkg::cmd_t                 cmd,
  output actc_pkg::status_t              status,
  input  logic [actc_pkg::IN_W-1:0]       s_tdata,
  input  logic [actc_pkg::OP_W-1:0]       s_tuser,
  input  logic                           cfg_valid,
  input  logic [actc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [actc_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [actc_pkg::OUT_W-1:0]      m_tdata
);
  import actc_pkg::*;

  localparam logic signed [AP_W-1:0] AP_MAX =
    $signed({{(AP_W-VW+1){1'b0}}, {(VW-1){1'b1}}});
  localparam logic signed [AP_W-1:0] AP_MIN = ~AP_MAX;
  localparam logic signed [AP_W-1:0] VD_MAX =
    $signed({{(AP_W-VD_W+1){1'b0}}, {(VD_W-1){1'b1}}});
  localparam logic signed [AP_W-1:0] VD_MIN = ~VD_MAX;

  function automatic logic signed [VW-1:0] sat_v(input logic signed [AP_W-1:0] x);
    if (x > AP_MAX) return AP_MAX[VW-1:0];
    else if (x < AP_MIN) return AP_MIN[VW-1:0];
    else return x[VW-1:0];
  endfunction

  function automatic logic signed [VD_W-1:0] sat_vd(input logic signed [AP_W-1:0] x);
    if (x > VD_MAX) return VD_MAX[VD_W-1:0];
    else if (x < VD_MIN) return VD_MIN[VD_W-1:0];
    else return x[VD_W-1:0];
  endfunction

  logic [LR_W-1:0] learn_rate;
  logic [LR_W-1:0] discount;
  logic [AS_W-1:0] actor_step;

  op_t                    op;
  logic [SW-1:0]          ps;
  logic [SW-1:0]          cs;
  logic [ACT_W-1:0]       act;
  logic signed [REW_W-1:0] reward;

  logic signed [VW-1:0] critic_mem [NS];
  row_t                 actor_mem [NS];
  logic [SW-1:0]        rd_addr;
  logic signed [VW-1:0] critic_rd;
  row_t                 actor_rd;
  logic                 c_we;
  logic                 a_we;
  logic [SW-1:0]        w_addr;
  logic signed [VW-1:0] c_wdata;
  row_t                 a_wdata;

  logic signed [VW-1:0]   v;
  logic signed [VW-1:0]   pv;
  row_t                   rowc;
  row_t                   rowp;
  row_t                   rown;
  logic signed [GP_W-1:0] gprod;
  logic signed [GP_W-1:0] g_sh;
  logic signed [TD_W-1:0] td;
  logic signed [AP_W-1:0] aprod;
  logic signed [AP_W-1:0] a_sh;
  logic signed [AP_W-1:0] nv_full;
  logic signed [VW-1:0]   new_v;

  logic                    improved;
  logic                    hit;
  logic signed [AP_W-1:0]  ent_add;
  row_t                    row_add;
  logic signed [SUM_W-1:0] sum_c;
  logic signed [SUM_W-1:0] sum;

  logic signed [VW-1:0]    ent_v;
  logic [VW-1:0]           emag;
  logic [SUM_W-1:0]        smag;
  logic [DVD_W-1:0]        dvd;
  logic [DVD_W-1:0]        quot;
  logic                    div_done;
  logic                    neg_q;
  logic signed [AP_W-1:0]  q_ext;

  row_t                    row_after;
  logic [AW-1:0]           best_cur;
  logic                    bc;
  logic signed [AP_W-1:0]  d_ext;
  logic signed [VD_W-1:0]  vd;
  logic [OUT_W-1:0]        out_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate <= LEARN_RATE_RST;
      discount <= DISCOUNT_RST;
      actor_step <= ACTOR_STEP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LEARN_RATE: learn_rate <= cfg_data[LR_W-1:0];
        REG_DISCOUNT:   discount <= cfg_data[LR_W-1:0];
        REG_ACTOR_STEP: actor_step <= cfg_data[AS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op <= op_t'(s_tuser);
      ps <= s_tdata[PS_LSB +: SW];
      cs <= s_tdata[CS_LSB +: SW];
      act <= s_tdata[ACT_LSB +: ACT_W];
      reward <= $signed(s_tdata[REW_LSB +: REW_W]);
    end
  end

  // table memories
  assign rd_addr = cmd.rd_prev ? ps : cs;
  assign c_we = cmd.clr | cmd.wr_critic;
  assign a_we = cmd.clr | cmd.wr_actor;
  assign w_addr = cmd.clr ? cmd.clr_addr : ps;
  assign c_wdata = cmd.clr ? '0 : new_v;
  assign a_wdata = cmd.clr ? '0 : rown;

  always_ff @(posedge clk) begin
    if (c_we) critic_mem[w_addr] <= c_wdata;
    critic_rd <= critic_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (a_we) actor_mem[w_addr] <= a_wdata;
    actor_rd <= actor_mem[rd_addr];
  end

  // critic update
  assign g_sh = (gprod + $signed(GP_W'(ROUND))) >>> LR_W;
  assign a_sh = (aprod + $signed(AP_W'(ROUND))) >>> LR_W;
  assign nv_full = AP_W'(pv) + a_sh;
  assign new_v = sat_v(nv_full);

  always_ff @(posedge clk) begin
    if (cmd.cap_cur) begin
      v <= critic_rd;
      rowc <= actor_rd;
    end
    if (cmd.cap_prev) begin
      pv <= critic_rd;
      rowp <= actor_rd;
    end
    if (cmd.mul_g) gprod <= GP_W'($signed({1'b0, discount})) * GP_W'(v);
    if (cmd.td_calc) td <= TD_W'(reward) + TD_W'(g_sh) - TD_W'(pv);
    if (cmd.mul_a) aprod <= AP_W'($signed({1'b0, learn_rate})) * AP_W'(td);
  end

  // actor add and row sum
  assign improved = v > pv;

  always_comb begin
    sum_c = '0;
    hit = 1'b0;
    ent_add = '0;
    row_add = rowp;
    for (int a = 0; a < NA; a++) begin
      hit = improved ? (int'(act) == a) : (int'(act) != a);
      ent_add = AP_W'($signed(rowp[a])) + AP_W'($signed({1'b0, actor_step}));
      row_add[a] = hit ? sat_v(ent_add) : rowp[a];
      sum_c = sum_c + SUM_W'($signed(row_add[a]));
    end
  end

  // normalization operands
  assign ent_v = $signed(rown[cmd.ent]);
  assign emag = ent_v[VW-1] ? VW'(-ent_v) : ent_v;
  assign smag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign dvd = {emag, {FRAC_W{1'b0}}};
  assign q_ext = AP_W'($signed({1'b0, quot}));

  actc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (smag),
    .done     (div_done),
    .quot     (quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.add_row) begin
      rown <= row_add;
      sum <= sum_c;
    end else if (div_done) begin
      rown[cmd.ent] <= sat_v(neg_q ? -q_ext : q_ext);
    end
    if (cmd.div_start) neg_q <= ent_v[VW-1] ^ sum[SUM_W-1];
  end

  // best action flag and result
  assign best_cur = row_argmax(rowc);
  assign row_after = (cs == ps) ? rown : rowc;
  assign d_ext = AP_W'(v) - AP_W'(pv);
  assign vd = sat_vd(d_ext);

  always_ff @(posedge clk) begin
    if (cmd.wr_actor) bc <= improved && (row_argmax(row_after) != best_cur);
    if (cmd.load_out) begin
      case (op)
        OP_CRITIC: out_data <= OUT_W'({{CH_W{1'b0}}, 1'b0, vd});
        OP_ACTOR:  out_data <= OUT_W'({{CH_W{1'b0}}, bc, {VD_W{1'b0}}});
        OP_CHOOSE: out_data <= OUT_W'({CH_W'(best_cur), 1'b0, {VD_W{1'b0}}});
        default:   out_data <= '0;
      endcase
    end
  end

  assign m_tdata = out_data;
  assign status.op = op;
  assign status.sum_zero = (sum == '0);
  assign status.div_done = div_done;

endmodule

[rtl/actc_ctrl.sv]
// sequencer of the learner: clearing pass, item steps, result handoff
`include "actor_critic_table_learner_macros.svh"

module actc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  actc_pkg::status_t status,
  output actc_pkg::cmd_t    cmd
);
  import actc_pkg::*;

  state_t        state;
  state_t        state_next;
  logic [SW-1:0] clr_cnt;
  logic [SW-1:0] clr_cnt_next;
  logic [AW-1:0] ent;
  logic [AW-1:0] ent_next;
  logic          out_valid;
  logic          out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      ent <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      clr_cnt <= clr_cnt_next;
      ent <= ent_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    clr_cnt_next = clr_cnt;
    ent_next = ent;
    cmd = '0;
    cmd.clr_addr = clr_cnt;
    cmd.ent = ent;
    case (state)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == SW'(NS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = ST_RD_CUR;
        end
      end
      ST_RD_CUR: state_next = ST_RD_PREV;
      ST_RD_PREV: begin
        cmd.rd_prev = 1'b1;
        cmd.cap_cur = 1'b1;
        state_next = ST_CAPTURE;
      end
      ST_CAPTURE: begin
        cmd.cap_prev = 1'b1;
        case (status.op)
          OP_CRITIC: state_next = ST_MUL_G;
          OP_ACTOR:  state_next = ST_ADD;
          default:   state_next = ST_OUT;
        endcase
      end
      ST_MUL_G: begin
        cmd.mul_g = 1'b1;
        state_next = ST_TD;
      end
      ST_TD: begin
        cmd.td_calc = 1'b1;
        state_next = ST_MUL_A;
      end
      ST_MUL_A: begin
        cmd.mul_a = 1'b1;
        state_next = ST_WR_CRITIC;
      end
      ST_WR_CRITIC: begin
        cmd.wr_critic = 1'b1;
        state_next = ST_OUT;
      end
      ST_ADD: begin
        cmd.add_row = 1'b1;
        ent_next = '0;
        state_next = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        if (status.sum_zero) begin
          state_next = ST_WR_ACTOR;
        end else begin
          cmd.div_start = 1'b1;
          state_next = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          if (ent == AW'(NA - 1)) begin
            state_next = ST_WR_ACTOR;
          end else begin
            ent_next = ent + 1'b1;
            state_next = ST_DIV_GO;
          end
        end
      end
      ST_WR_ACTOR: begin
        cmd.wr_actor = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) out_valid_next = 1'b1;
    else if (m_tready) out_valid_next = 1'b0;
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;

  `ACTC_ASSERT_NXT(a_load_sets_valid, cmd.load_out, out_valid)
  `ACTC_ASSERT_IMP(a_load_when_free, cmd.load_out, !out_valid || m_tready)
  `ACTC_ASSERT_IMP(a_start_nonzero, cmd.div_start, !status.sum_zero)
  `ACTC_ASSERT_NXT(a_last_entry, state == ST_DIV_WAIT && status.div_done && ent == AW'(NA - 1), state == ST_WR_ACTOR)

endmodule

[rtl/actor_critic_table_learner.sv]
// top level of the tabular actor-critic learner
//
//  channel  dir  handshake           payload
//  s        in   s_tvalid/s_tready   s_tdata, s_tuser (opcode)
//  m        out  m_tvalid/m_tready   m_tdata
//  cfg      in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// steps: read, capture; critic scales by discount, forms TD, scales by learning rate, writes;
// actor adds to the row, divides each entry by a nonzero row sum, writes; others go to output
// after reset a clearing pass zeroes all 1024 entries of both tables, no item taken
// a finished result waits in the output register; the next item is taken meanwhile
// and holds in its last cycle while the previous result is still unread
// cfg writes are always ready
module actor_critic_table_learner (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // prev_state, cur_state, taken_action, reward, zero pad
  input  logic [actc_pkg::IN_W-1:0]       s_tdata,
  // opcode
  input  logic [actc_pkg::OP_W-1:0]       s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // value_delta, best_changed, chosen_action, zero pad
  output logic [actc_pkg::OUT_W-1:0]      m_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [actc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [actc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import actc_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  actc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  actc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tdata   (m_tdata)
  );

endmodule

[tb/sv/tb_actor_critic_table_learner.sv]
// self-checking testbench of the tabular actor-critic learner
module tb_actor_critic_table_learner;
  timeunit 1ns;
  timeprecision 1ps;
  import actc_pkg::*;

  class learner_board;
    longint critic_val[NS];
    longint actor_pref[NS*NA];
    longint unsigned alpha, gamma, step;
    logic [OUT_W-1:0] results_due[$];
    int errors;

    function new();
      foreach (critic_val[i]) critic_val[i] = 0;
      foreach (actor_pref[i]) actor_pref[i] = 0;
      alpha = 31130;
      gamma = 29491;
      step = 19661;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_LEARN_RATE: alpha = d[14:0];
        REG_DISCOUNT:   gamma = d[14:0];
        REG_ACTOR_STEP: step = d;
        default: ;
      endcase
    endfunction

    function longint clip32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function int best_of(int s);
      int b;
      b = 0;
      for (int a = 1; a < NA; a++)
        if (actor_pref[s*NA+a] > actor_pref[s*NA+b]) b = a;
      return b;
    endfunction

    function void note_item(op_t op, int ps, int cs, int act, logic signed [31:0] rew);
      longint v, pv, gv, td, hi, lo, stp, sum, e, q;
      longint unsigned smag, emag;
      logic [OUT_W-1:0] r;
      logic improved;
      int best_prior;
      r = '0;
      v = critic_val[cs];
      pv = critic_val[ps];
      case (op)
        OP_CRITIC: begin
          gv = (longint'(gamma) * v + 16384) >>> 15;
          td = longint'(rew) + gv - pv;
          hi = td >>> 15;
          lo = td - hi * 32768;
          stp = longint'(alpha) * hi + ((longint'(alpha) * lo + 16384) >>> 15);
          critic_val[ps] = clip32(pv + stp);
          r[31:0] = 32'(clip32(v - pv));
        end
        OP_ACTOR: begin
          improved = v > pv;
          best_prior = best_of(cs);
          sum = 0;
          for (int a = 0; a < NA; a++) begin
            if (improved ? (a == act) : (a != act))
              actor_pref[ps*NA+a] = clip32(actor_pref[ps*NA+a] + longint'(step));
            sum += actor_pref[ps*NA+a];
          end
          if (sum != 0) begin
            smag = sum < 0 ? -sum : sum;
            for (int a = 0; a < NA; a++) begin
              e = actor_pref[ps*NA+a];
              emag = e < 0 ? -e : e;
              q = longint'((emag << 16) / smag);
              actor_pref[ps*NA+a] = clip32(((e < 0) != (sum < 0)) ? -q : q);
            end
          end
          r[32] = improved && (best_of(cs) != best_prior);
        end
        OP_CHOOSE: r[34:33] = 2'(best_of(cs));
        default: ;
      endcase
      results_due.push_back(r);
    endfunction

    function void check_result(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] w;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      w = results_due.pop_front();
      if (got[31:0] !== w[31:0]) begin
        $display("%0t: value_delta expected %h actual %h", $time, w[31:0], got[31:0]);
        errors++;
      end
      if (got[32] !== w[32]) begin
        $display("%0t: best_changed expected %b actual %b", $time, w[32], got[32]);
        errors++;
      end
      if (got[34:33] !== w[34:33]) begin
        $display("%0t: chosen_action expected %0d actual %0d", $time, w[34:33], got[34:33]);
        errors++;
      end
      if (got[39:35] !== w[39:35]) begin
        $display("%0t: pad expected %h actual %h", $time, w[39:35], got[39:35]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic [OP_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  learner_board board = new();
  int snd_idle = 0;
  int rcv_idle = 0;
  int hold_left = 0;

  always #5 clk = ~clk;

  actor_critic_table_learner i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
      @(negedge clk);
      if (hold_left > 0) begin
        m_tready = 0;
        hold_left--;
      end else begin
        m_tready = ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  task automatic send(op_t op, int ps, int cs, int act, logic [31:0] rew);
    while ($urandom_range(99) < snd_idle) begin
      s_tvalid = 0;
      @(negedge clk);
    end
    s_tvalid = 1;
    s_tuser = op;
    s_tdata = {2'b00, rew, act[1:0], cs[9:0], ps[9:0]};
    do @(posedge clk); while (!s_tready);
    board.note_item(op, ps, cs, act, rew);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid = 0;
    while (board.results_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = d;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, d);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic set_all(int lr, int g, int st);
    write_reg(REG_LEARN_RATE, CFG_DATA_W'(lr));
    write_reg(REG_DISCOUNT, CFG_DATA_W'(g));
    write_reg(REG_ACTOR_STEP, CFG_DATA_W'(st));
  endtask

  function automatic int pick_state();
    return ($urandom_range(99) < 80) ? $urandom_range(15) : $urandom_range(1023);
  endfunction

  function automatic logic [31:0] pick_reward();
    int k;
    k = $urandom_range(99);
    if (k < 60) return $signed($urandom_range(8 << 16)) - (4 << 16);
    if (k < 90) return $urandom;
    if (k < 95) return 32'h7fffffff;
    return 32'h80000000;
  endfunction

  task automatic random_items(int n);
    int k;
    op_t op;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      op = k < 35 ? OP_CRITIC : k < 70 ? OP_ACTOR : k < 95 ? OP_CHOOSE : OP_NONE;
      send(op, pick_state(), pick_state(), $urandom_range(3), pick_reward());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;
    // directed items at reset settings
    send(OP_CHOOSE, 0, 0, 0, 0);
    send(OP_CRITIC, 1, 2, 0, 32'h7fffffff);
    send(OP_CRITIC, 2, 1, 0, 32'h80000000);
    send(OP_CRITIC, 3, 3, 0, 32'h00010000);
    send(OP_CRITIC, 1023, 1023, 3, 32'h7fffffff);
    send(OP_CRITIC, 0, 1023, 0, 0);
    send(OP_ACTOR, 1, 2, 1, 0);
    send(OP_ACTOR, 2, 1, 2, 32'hffffffff);
    send(OP_ACTOR, 3, 3, 3, 0);
    send(OP_ACTOR, 1023, 0, 3, 0);
    send(OP_ACTOR, 0, 1023, 0, 0);
    send(OP_ACTOR, 2, 2, 0, 0);
    send(OP_CHOOSE, 0, 1, 0, 0);
    send(OP_CHOOSE, 0, 2, 0, 0);
    send(OP_CHOOSE, 0, 1023, 0, 0);
    send(OP_NONE, 1023, 1023, 3, 32'hffffffff);
    send(OP_CHOOSE, 1023, 3, 3, 0);
    drain();
    // zero steps leave zero rows alone
    set_all(0, 0, 0);
    send(OP_ACTOR, 700, 700, 1, 0);
    send(OP_CRITIC, 700, 1, 0, 32'h7fffffff);
    send(OP_CHOOSE, 0, 700, 0, 0);
    drain();
    set_all(32767, 32767, 2147483647);
    send(OP_ACTOR, 5, 6, 2, 0);
    send(OP_ACTOR, 5, 5, 0, 0);
    send(OP_CRITIC, 7, 7, 0, 32'h7fffffff);
    drain();
    snd_idle = 25;
    rcv_idle = 72;
    set_all(31130, 29491, 19661);
    random_items(300);
    hold_left = 400;
    random_items(80);
    drain();
    snd_idle = 72;
    rcv_idle = 25;
    set_all($urandom_range(32767), $urandom_range(32767), $urandom_range(1 << 20));
    random_items(300);
    drain();
    snd_idle = 0;
    rcv_idle = 0;
    set_all(32767, 0, $urandom);
    random_items(200);
    drain();
    set_all(1, 32767, 1);
    random_items(250);
    drain();
    repeat (50) @(negedge clk);
    if (board.errors == 0 && board.results_due.size() == 0)
      $display("tb_actor_critic_table_learner: clean");
    else
      $display("tb_actor_critic_table_learner: errors");
    $finish;
  end

  initial begin
    #50ms;
    $display("tb_actor_critic_table_learner: errors");
    $finish;
  end
endmodule
